### rtl/psgtne_pkg.sv
// Shared types, codes, tables and helper functions of the sound generator.
// No dependencies; every other file refers to it by scoped names.
package psgtne_pkg;

    // Phase accumulator fraction width and its sum width
    localparam int FRAC_BITS = 24;
    localparam int SUM_W     = 40;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_LATCH = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_INC  = 2'd0,
        CFG_VOL_MODE  = 2'd1,
        CFG_MUTE      = 2'd2,
        CFG_STEREO    = 2'd3
    } cfg_idx_t;

    localparam logic [31:0] STEP_INC_RESET = 32'h0100_0000;
    localparam logic [5:0]  STEREO_RESET   = 6'h3f;

    // Register file places
    localparam logic [3:0] REG_NOISE_PER  = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_VOL_A      = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

    // The top tap sits one bit above the shift register and lands in bit 16 after the shift
    localparam logic [16:0] LFSR_RESET = 17'h0ffff;
    localparam logic [17:0] LFSR_TAPS  = 18'h24000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic        is_sample;
        logic [7:0]  read_data;
        logic [12:0] level_a;
        logic [12:0] level_b;
        logic [12:0] level_c;
        logic [14:0] left_sum;
        logic [14:0] right_sum;
    } out_item_t;

    // Per-channel control from the core to the mixer
    typedef struct packed {
        logic       audible;
        logic [4:0] vol_idx;
    } chan_ctl_t;

    typedef struct packed {
        logic       hit;
        logic [16:0] cnt;
    } div_res_t;

    localparam logic [7:0] YM_LEVELS [32] = '{
        8'h00, 8'h01, 8'h01, 8'h02, 8'h02, 8'h03, 8'h03, 8'h04,
        8'h05, 8'h06, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h0F, 8'h12,
        8'h16, 8'h1A, 8'h1F, 8'h25, 8'h2D, 8'h35, 8'h3F, 8'h4C,
        8'h5A, 8'h6A, 8'h7F, 8'h97, 8'hB4, 8'hD6, 8'hFF, 8'hFF
    };

    localparam logic [7:0] AY_LEVELS [32] = '{
        8'h00, 8'h00, 8'h03, 8'h03, 8'h04, 8'h04, 8'h06, 8'h06,
        8'h09, 8'h09, 8'h0D, 8'h0D, 8'h12, 8'h12, 8'h1D, 8'h1D,
        8'h22, 8'h22, 8'h37, 8'h37, 8'h4D, 8'h4D, 8'h62, 8'h62,
        8'h82, 8'h82, 8'hA6, 8'hA6, 8'hD0, 8'hD0, 8'hFF, 8'hFF
    };

    // Implemented bits of each register
    function automatic logic [7:0] reg_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0f;
            4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1f;
            4'd7:                    m = 8'h3f;
            default:                 m = 8'hff;
        endcase
        return m;
    endfunction

    // Volume table lookup: mode 0 selects the 32-step table
    function automatic logic [7:0] level_of(input logic mode, input logic [4:0] idx);
        return mode ? AY_LEVELS[idx] : YM_LEVELS[idx];
    endfunction

    // Advance a divider by the carry; wide selects a 17-bit counter, else 16-bit
    function automatic div_res_t div_step(input logic [16:0] cnt, input logic [15:0] period,
                                          input logic [7:0] carry, input logic wide);
        logic [16:0] s;
        div_res_t    r;
        s = cnt + {9'd0, carry};
        if (!wide) begin
            s[16] = 1'b0;
        end
        r.hit = (s >= {1'b0, period});
        if (!r.hit) begin
            r.cnt = s;
        end else if (period >= {8'd0, carry}) begin
            r.cnt = s - {1'b0, period};
        end else begin
            r.cnt = '0;
        end
        return r;
    endfunction

endpackage

### rtl/psgtne_phase.sv
// Fixed-point tick phase accumulator; holds the step increment register.
// Depends on psgtne_pkg.
module psgtne_phase (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        inc_we,
    input  logic [31:0] inc_data,
    input  logic        advance,
    output logic [7:0]  carry
);

    logic [31:0]                    step_inc_reg;
    logic [psgtne_pkg::FRAC_BITS-1:0] phase_reg;
    logic [psgtne_pkg::FRAC_BITS-1:0] phase_next;
    logic [psgtne_pkg::SUM_W-1:0]     sum;

    // Add the increment; whole steps carry out above the fraction
    always_comb begin
        sum = {{(psgtne_pkg::SUM_W-psgtne_pkg::FRAC_BITS){1'b0}}, phase_reg}
            + {{(psgtne_pkg::SUM_W-32){1'b0}}, step_inc_reg};
        carry      = sum[psgtne_pkg::FRAC_BITS +: 8];
        phase_next = sum[psgtne_pkg::FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_inc_reg <= psgtne_pkg::STEP_INC_RESET;
            phase_reg    <= '0;
        end else begin
            if (inc_we) begin
                step_inc_reg <= inc_data;
            end
            if (advance) begin
                phase_reg <= phase_next;
            end
        end
    end

endmodule

### rtl/psgtne_core.sv
// Register file, address latch, tone/noise/envelope dividers and their update.
// Depends on psgtne_pkg.
module psgtne_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  psgtne_pkg::in_item_t  item,
    input  logic [7:0]            carry,
    output logic [7:0]            read_byte,
    output psgtne_pkg::chan_ctl_t ctl [3]
);

    logic [7:0]  regfile_reg [16];
    logic [4:0]  addr_reg;
    logic [15:0] tone_cnt_reg [3];
    logic [15:0] tone_cnt_next [3];
    logic [2:0]  tone_edge_reg;
    logic [2:0]  tone_edge_next;
    logic [16:0] noise_shift_reg;
    logic [16:0] noise_shift_next;
    logic [17:0] noise_fb;
    logic        noise_pre_reg;
    logic        noise_pre_next;
    logic [15:0] noise_cnt_reg;
    logic [15:0] noise_cnt_next;
    logic [16:0] env_cnt_reg;
    logic [16:0] env_cnt_next;
    logic [4:0]  env_step_reg;
    logic [4:0]  env_step_next;
    logic        env_dir_reg;
    logic        env_dir_next;
    logic        env_paused_reg;
    logic        env_paused_next;

    logic        do_latch;
    logic        do_write;
    logic        do_tick;
    logic [7:0]  wr_byte;
    logic [7:0]  shape;
    logic [7:0]  mixer;
    logic [5:0]  step6;
    psgtne_pkg::div_res_t env_div;
    psgtne_pkg::div_res_t noise_div;
    psgtne_pkg::div_res_t tone_div [3];

    assign do_latch = go && (item.kind == psgtne_pkg::KIND_LATCH);
    assign do_write = go && (item.kind == psgtne_pkg::KIND_WRITE) && !addr_reg[4];
    assign do_tick  = go && (item.kind == psgtne_pkg::KIND_TICK);
    assign wr_byte  = item.write_data & psgtne_pkg::reg_mask(addr_reg[3:0]);
    assign shape    = regfile_reg[psgtne_pkg::REG_ENV_SHAPE];
    assign mixer    = regfile_reg[psgtne_pkg::REG_MIXER];

    // Read back the latched register; addresses above fifteen read zero
    assign read_byte = addr_reg[4] ? 8'd0 : regfile_reg[addr_reg[3:0]];

    // Envelope divider and shape walk
    always_comb begin
        env_div = psgtne_pkg::div_step(env_cnt_reg,
                                       {regfile_reg[psgtne_pkg::REG_ENV_COARSE],
                                        regfile_reg[psgtne_pkg::REG_ENV_FINE]},
                                       carry, 1'b1);
        env_cnt_next    = env_div.cnt;
        step6           = {1'b0, env_step_reg};
        env_dir_next    = env_dir_reg;
        env_paused_next = env_paused_reg;
        if (env_div.hit) begin
            if (!env_paused_reg) begin
                step6 = env_dir_reg ? step6 + 6'd1 : step6 - 6'd1;
            end
            if (step6[5]) begin
                if (shape[3]) begin
                    if (shape[1] ^ shape[0]) begin
                        env_dir_next = !env_dir_reg;
                    end
                    if (shape[0]) begin
                        env_paused_next = 1'b1;
                    end
                    step6 = env_dir_next ? 6'd0 : 6'h1f;
                end else begin
                    env_paused_next = 1'b1;
                    step6           = 6'd0;
                end
            end
        end
        env_step_next = step6[4:0];
    end

    // Noise divider; shift the LFSR on every second overflow
    always_comb begin
        noise_div = psgtne_pkg::div_step({1'b0, noise_cnt_reg},
                                         {11'd0, regfile_reg[psgtne_pkg::REG_NOISE_PER][4:0]},
                                         carry, 1'b0);
        noise_cnt_next   = noise_div.cnt[15:0];
        noise_pre_next   = noise_pre_reg ^ noise_div.hit;
        noise_fb         = {1'b0, noise_shift_reg}
                         ^ (noise_shift_reg[0] ? psgtne_pkg::LFSR_TAPS : 18'd0);
        noise_shift_next = noise_shift_reg;
        if (noise_div.hit && noise_pre_next) begin
            noise_shift_next = noise_fb[17:1];
        end
    end

    // Tone dividers and the gating seen by the mixer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tone_div[i] = psgtne_pkg::div_step({1'b0, tone_cnt_reg[i]},
                                               {4'd0, regfile_reg[2*i+1][3:0], regfile_reg[2*i]},
                                               carry, 1'b0);
            tone_cnt_next[i]  = tone_div[i].cnt[15:0];
            tone_edge_next[i] = tone_edge_reg[i] ^ tone_div[i].hit;
            ctl[i].audible    = (mixer[i] || tone_edge_next[i])
                             && (mixer[i+3] || noise_shift_next[0]);
            ctl[i].vol_idx    = regfile_reg[psgtne_pkg::REG_VOL_A + 4'(i)][4]
                              ? env_step_next
                              : {regfile_reg[psgtne_pkg::REG_VOL_A + 4'(i)][3:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                regfile_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                tone_cnt_reg[i] <= '0;
            end
            addr_reg        <= '0;
            tone_edge_reg   <= '0;
            noise_shift_reg <= psgtne_pkg::LFSR_RESET;
            noise_pre_reg   <= 1'b0;
            noise_cnt_reg   <= '0;
            env_cnt_reg     <= '0;
            env_step_reg    <= '0;
            env_dir_reg     <= 1'b0;
            env_paused_reg  <= 1'b1;
        end else begin
            if (do_latch) begin
                addr_reg <= item.write_data[4:0];
            end
            // Register write; a shape write restarts the envelope
            if (do_write) begin
                regfile_reg[addr_reg[3:0]] <= wr_byte;
                if (addr_reg[3:0] == psgtne_pkg::REG_ENV_SHAPE) begin
                    env_dir_reg    <= wr_byte[2];
                    env_paused_reg <= 1'b0;
                    env_step_reg   <= wr_byte[2] ? 5'd0 : 5'h1f;
                end
            end
            if (do_tick) begin
                for (int i = 0; i < 3; i++) begin
                    tone_cnt_reg[i] <= tone_cnt_next[i];
                end
                tone_edge_reg   <= tone_edge_next;
                noise_shift_reg <= noise_shift_next;
                noise_pre_reg   <= noise_pre_next;
                noise_cnt_reg   <= noise_cnt_next;
                env_cnt_reg     <= env_cnt_next;
                env_step_reg    <= env_step_next;
                env_dir_reg     <= env_dir_next;
                env_paused_reg  <= env_paused_next;
            end
        end
    end

endmodule

### rtl/psgtne_mix.sv
// Volume table lookup, muting and stereo summing of the three channels.
// Depends on psgtne_pkg.
module psgtne_mix (
    input  logic                  vol_mode,
    input  logic [2:0]            mute_mask,
    input  logic [5:0]            pan_bits,
    input  psgtne_pkg::chan_ctl_t ctl [3],
    output logic [12:0]           level [3],
    output logic [14:0]           left_sum,
    output logic [14:0]           right_sum
);

    // Look up levels, then add those enabled on each side
    always_comb begin
        left_sum  = '0;
        right_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (ctl[i].audible && !mute_mask[i]) begin
                level[i] = {psgtne_pkg::level_of(vol_mode, ctl[i].vol_idx), 5'd0};
            end else begin
                level[i] = '0;
            end
            if (pan_bits[2*i]) begin
                left_sum = left_sum + {2'd0, level[i]};
            end
            if (pan_bits[2*i+1]) begin
                right_sum = right_sum + {2'd0, level[i]};
            end
        end
    end

endmodule

### rtl/psg_tone_noise_envelope_generator.sv
// Top level of the three-channel tone/noise/envelope sound generator.
// Depends on psgtne_pkg, psgtne_phase, psgtne_core and psgtne_mix.

// The block takes one item per clock: latch, write, read or tick. An accepted
// item is held in an input register and processed there; its result (reads
// and ticks only) is captured in a result register and shown on m_data with
// m_valid. A full result register that is not taken stalls reads and ticks
// in the input register, and s_ready then drops. The tick phase accumulator
// is advanced at acceptance so the whole-step carry arrives registered;
// divider, envelope, table lookup and stereo sums enter the result register.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata
// while idle; the user must keep to this, the block does not enforce it.
module psg_tone_noise_envelope_generator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  psgtne_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output psgtne_pkg::out_item_t m_data,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    psgtne_pkg::in_item_t  in_item_reg;
    logic [7:0]            carry_reg;
    logic [7:0]            carry;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    psgtne_pkg::out_item_t out_item_reg;
    psgtne_pkg::out_item_t out_item_next;

    logic                  vol_mode_reg;
    logic [2:0]            mute_reg;
    logic [5:0]            stereo_reg;

    logic                  s_fire;
    logic                  has_result;
    logic                  go;
    logic [7:0]            read_byte;
    psgtne_pkg::chan_ctl_t ctl [3];
    logic [12:0]           level [3];
    logic [14:0]           left_sum;
    logic [14:0]           right_sum;

    // Handshake: process when the result register can take the outcome
    assign has_result = (in_item_reg.kind == psgtne_pkg::KIND_READ)
                     || (in_item_reg.kind == psgtne_pkg::KIND_TICK);
    assign go         = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || go;
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_item_reg;

    psgtne_phase u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .inc_we   (cfg_wr_en && (cfg_index == psgtne_pkg::CFG_STEP_INC)),
        .inc_data (cfg_wdata),
        .advance  (s_fire && (s_data.kind == psgtne_pkg::KIND_TICK)),
        .carry    (carry)
    );

    psgtne_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .item      (in_item_reg),
        .carry     (carry_reg),
        .read_byte (read_byte),
        .ctl       (ctl)
    );

    psgtne_mix u_mix (
        .vol_mode  (vol_mode_reg),
        .mute_mask (mute_reg),
        .pan_bits  (stereo_reg),
        .ctl       (ctl),
        .level     (level),
        .left_sum  (left_sum),
        .right_sum (right_sum)
    );

    // Build the result item and advance the valid flags
    always_comb begin
        in_valid_next = s_fire ? 1'b1 : (go ? 1'b0 : in_valid_reg);
        out_item_next = '0;
        if (in_item_reg.kind == psgtne_pkg::KIND_TICK) begin
            out_item_next.is_sample = 1'b1;
            out_item_next.level_a   = level[0];
            out_item_next.level_b   = level[1];
            out_item_next.level_c   = level[2];
            out_item_next.left_sum  = left_sum;
            out_item_next.right_sum = right_sum;
        end else begin
            out_item_next.read_data = read_byte;
        end
        if (go && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Input register and carry captured at acceptance; result stored when due
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_data;
            carry_reg   <= carry;
        end
        if (go && has_result) begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vol_mode_reg  <= 1'b0;
            mute_reg      <= '0;
            stereo_reg    <= psgtne_pkg::STEREO_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    psgtne_pkg::CFG_VOL_MODE: vol_mode_reg <= cfg_wdata[0];
                    psgtne_pkg::CFG_MUTE:     mute_reg     <= cfg_wdata[2:0];
                    psgtne_pkg::CFG_STEREO:   stereo_reg   <= cfg_wdata[5:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/psgtne_checker.sv
// Port-level checks for the sound generator, bound to its top level.
// Depends on psgtne_pkg and psg_tone_noise_envelope_generator.
module psgtne_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input psgtne_pkg::out_item_t m_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Clear the result channel out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Read results carry no levels
    a_read_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_sample |-> m_data.level_a == 13'd0
            && m_data.level_b == 13'd0 && m_data.level_c == 13'd0
            && m_data.left_sum == 15'd0 && m_data.right_sum == 15'd0)
        else $error("read result with nonzero levels");

    // Samples carry no read byte and their sums never exceed the channel total
    a_sample_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_sample |-> m_data.read_data == 8'd0
            && m_data.left_sum <= ({2'd0, m_data.level_a} + {2'd0, m_data.level_b}
                                   + {2'd0, m_data.level_c})
            && m_data.right_sum <= ({2'd0, m_data.level_a} + {2'd0, m_data.level_b}
                                    + {2'd0, m_data.level_c}))
        else $error("sample sums inconsistent");

    // Levels are table values shifted left five
    a_level_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.level_a[4:0] == 5'd0 && m_data.level_b[4:0] == 5'd0
            && m_data.level_c[4:0] == 5'd0)
        else $error("level not aligned");

endmodule

bind psg_tone_noise_envelope_generator psgtne_checker u_psgtne_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### bench/psg_tone_noise_envelope_generator_test.sv
// Self-checking bench for the three-channel tone/noise/envelope sound generator.
// Drives bus and tick items, predicts every read and sample, compares field by field.
// Depends on psgtne_pkg and psg_tone_noise_envelope_generator.
module psg_tone_noise_envelope_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 100;
    // The top tap sits one bit above the 17-bit shift register
    localparam logic [17:0] NOISE_FEEDBACK = 18'h24000;

    // Volume tables, 32 entries each
    localparam logic [7:0] YM_TAB [32] = '{
        8'h00, 8'h01, 8'h01, 8'h02, 8'h02, 8'h03, 8'h03, 8'h04,
        8'h05, 8'h06, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h0F, 8'h12,
        8'h16, 8'h1A, 8'h1F, 8'h25, 8'h2D, 8'h35, 8'h3F, 8'h4C,
        8'h5A, 8'h6A, 8'h7F, 8'h97, 8'hB4, 8'hD6, 8'hFF, 8'hFF
    };
    localparam logic [7:0] AY_TAB [32] = '{
        8'h00, 8'h00, 8'h03, 8'h03, 8'h04, 8'h04, 8'h06, 8'h06,
        8'h09, 8'h09, 8'h0D, 8'h0D, 8'h12, 8'h12, 8'h1D, 8'h1D,
        8'h22, 8'h22, 8'h37, 8'h37, 8'h4D, 8'h4D, 8'h62, 8'h62,
        8'h82, 8'h82, 8'hA6, 8'hA6, 8'hD0, 8'hD0, 8'hFF, 8'hFF
    };
    // Implemented bits per register
    localparam logic [7:0] IMPL_BITS [16] = '{
        8'hff, 8'h0f, 8'hff, 8'h0f, 8'hff, 8'h0f, 8'h1f, 8'h3f,
        8'h1f, 8'h1f, 8'h1f, 8'hff, 8'hff, 8'h0f, 8'hff, 8'hff
    };

    typedef struct packed {
        logic        hit;
        logic [16:0] nxt;
    } divider_t;

    typedef struct {
        psgtne_pkg::in_item_t  it;
        bit                    typed;
        psgtne_pkg::out_item_t want;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    psgtne_pkg::in_item_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    psgtne_pkg::out_item_t m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [31:0]           cfg_wdata = '0;

    // Shadow configuration
    logic [31:0] cfg_step;
    logic        cfg_ay;
    logic [2:0]  cfg_mute;
    logic [5:0]  cfg_stereo;

    // Shadow chip state
    logic [7:0]  regs_m [16];
    logic [4:0]  latch_m;
    logic [23:0] phase_m;
    logic [15:0] tone_cnt [3];
    logic        tone_edge [3];
    logic [16:0] lfsr;
    logic        noise_half;
    logic [15:0] noise_cnt;
    logic [16:0] env_cnt;
    logic [5:0]  env_pos;
    logic        env_up;
    logic        env_frozen;

    psgtne_pkg::out_item_t responses_due [$];
    row_t                  script [$];
    int                    error_count = 0;
    int                    items_sent = 0;
    int                    s_gap_pct = 0;
    int                    r_gap_pct = 0;
    int                    stall_cycles = 0;

    psg_tone_noise_envelope_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Throttle the result side
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= r_gap_pct);
    end

    // Advance a divider by the carry; wrap_mask sets its width
    function automatic divider_t run_divider(logic [16:0] cnt, logic [16:0] period,
                                             logic [7:0] carry, logic [16:0] wrap_mask);
        divider_t    d;
        logic [16:0] c;
        c = (cnt + {9'd0, carry}) & wrap_mask;
        d.hit = (c >= period);
        d.nxt = c;
        if (d.hit) begin
            d.nxt = (period >= {9'd0, carry}) ? ((c - period) & wrap_mask) : 17'd0;
        end
        return d;
    endfunction

    function automatic psgtne_pkg::out_item_t read_of(logic [7:0] b);
        psgtne_pkg::out_item_t r;
        r = '0;
        r.read_data = b;
        return r;
    endfunction

    // Walk the envelope shape by the carry
    task automatic step_envelope(logic [7:0] carry);
        divider_t   d;
        logic [7:0] shape;
        d = run_divider(env_cnt, {1'b0, regs_m[psgtne_pkg::REG_ENV_COARSE],
                                  regs_m[psgtne_pkg::REG_ENV_FINE]},
                        carry, 17'h1ffff);
        env_cnt = d.nxt;
        shape = regs_m[psgtne_pkg::REG_ENV_SHAPE];
        if (d.hit) begin
            if (!env_frozen) begin
                env_pos = env_up ? env_pos + 6'd1 : env_pos - 6'd1;
            end
            if (env_pos[5]) begin
                if (shape[3]) begin
                    if (shape[1] ^ shape[0]) begin
                        env_up = ~env_up;
                    end
                    if (shape[0]) begin
                        env_frozen = 1'b1;
                    end
                    env_pos = env_up ? 6'd0 : 6'd31;
                end else begin
                    env_frozen = 1'b1;
                    env_pos = 6'd0;
                end
            end
        end
    endtask

    // Compute the chip's answer to one item and update the shadow state
    task automatic chip_response(psgtne_pkg::in_item_t it, output bit has_out,
                                 output psgtne_pkg::out_item_t r);
        logic [32:0] acc;
        logic [7:0]  carry;
        logic [7:0]  mixer;
        logic [4:0]  vol;
        logic [4:0]  idx;
        logic [12:0] lv [3];
        logic [14:0] left;
        logic [14:0] right;
        logic [17:0] fb;
        divider_t    d;
        r = '0;
        has_out = 1'b0;
        case (it.kind)
            psgtne_pkg::KIND_LATCH: begin
                latch_m = it.write_data[4:0];
            end
            psgtne_pkg::KIND_WRITE: begin
                if (!latch_m[4]) begin
                    regs_m[latch_m[3:0]] = it.write_data & IMPL_BITS[latch_m[3:0]];
                    // Shape write restarts the envelope
                    if (latch_m[3:0] == psgtne_pkg::REG_ENV_SHAPE) begin
                        env_up = regs_m[psgtne_pkg::REG_ENV_SHAPE][2];
                        env_frozen = 1'b0;
                        env_pos = env_up ? 6'd0 : 6'd31;
                    end
                end
            end
            psgtne_pkg::KIND_READ: begin
                has_out = 1'b1;
                r.read_data = latch_m[4] ? 8'd0 : regs_m[latch_m[3:0]];
            end
            default: begin
                has_out = 1'b1;
                // Carry keeps only eight whole-step bits
                acc = {9'd0, phase_m} + {1'b0, cfg_step};
                carry = acc[31:24];
                phase_m = acc[23:0];
                step_envelope(carry);
                d = run_divider({1'b0, noise_cnt},
                                {12'd0, regs_m[psgtne_pkg::REG_NOISE_PER][4:0]},
                                carry, 17'h0ffff);
                noise_cnt = d.nxt[15:0];
                if (d.hit) begin
                    noise_half = ~noise_half;
                    if (noise_half) begin
                        fb = {1'b0, lfsr};
                        if (lfsr[0]) begin
                            fb = fb ^ NOISE_FEEDBACK;
                        end
                        lfsr = fb[17:1];
                    end
                end
                mixer = regs_m[psgtne_pkg::REG_MIXER];
                left = '0;
                right = '0;
                for (int i = 0; i < 3; i++) begin
                    d = run_divider({1'b0, tone_cnt[i]},
                                    {5'd0, regs_m[2 * i + 1][3:0], regs_m[2 * i]},
                                    carry, 17'h0ffff);
                    tone_cnt[i] = d.nxt[15:0];
                    if (d.hit) begin
                        tone_edge[i] = ~tone_edge[i];
                    end
                    lv[i] = '0;
                    if (!cfg_mute[i]) begin
                        if ((mixer[i] || tone_edge[i]) && (mixer[i + 3] || lfsr[0])) begin
                            vol = regs_m[psgtne_pkg::REG_VOL_A + i][4:0];
                            idx = vol[4] ? env_pos[4:0] : {vol[3:0], 1'b0};
                            lv[i] = {(cfg_ay ? AY_TAB[idx] : YM_TAB[idx]), 5'd0};
                        end
                        if (cfg_stereo[2 * i]) begin
                            left = left + {2'd0, lv[i]};
                        end
                        if (cfg_stereo[2 * i + 1]) begin
                            right = right + {2'd0, lv[i]};
                        end
                    end
                end
                r.is_sample = 1'b1;
                r.level_a = lv[0];
                r.level_b = lv[1];
                r.level_c = lv[2];
                r.left_sum = left;
                r.right_sum = right;
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got_v, want_v);
        end
        error_count++;
    endtask

    // Compare one result with the oldest one due
    task automatic check_result(psgtne_pkg::out_item_t got);
        psgtne_pkg::out_item_t want;
        if (responses_due.size() == 0) begin
            report_mismatch("result with none due, is_sample", got.is_sample, 0);
        end else begin
            want = responses_due.pop_front();
            if (got.is_sample !== want.is_sample)
                report_mismatch("is_sample", got.is_sample, want.is_sample);
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.level_a !== want.level_a)
                report_mismatch("level_a", got.level_a, want.level_a);
            if (got.level_b !== want.level_b)
                report_mismatch("level_b", got.level_b, want.level_b);
            if (got.level_c !== want.level_c)
                report_mismatch("level_c", got.level_c, want.level_c);
            if (got.left_sum !== want.left_sum)
                report_mismatch("left_sum", got.left_sum, want.left_sum);
            if (got.right_sum !== want.right_sum)
                report_mismatch("right_sum", got.right_sum, want.right_sum);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one item, wait for its acceptance, record what it should produce
    task automatic push_item(logic [1:0] k, logic [7:0] d, bit typed,
                             psgtne_pkg::out_item_t want, bit hold_off);
        psgtne_pkg::in_item_t  it;
        psgtne_pkg::out_item_t pred;
        bit                    has_out;
        it.kind = k;
        it.write_data = d;
        if (hold_off || ($urandom_range(0, 99) < s_gap_pct)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (hold_off && responses_due.size() != 0) @(posedge aclk);
            while ($urandom_range(0, 99) < s_gap_pct) @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chip_response(it, has_out, pred);
        if (has_out) begin
            responses_due.push_back(typed ? want : pred);
        end
        items_sent++;
    endtask

    task automatic add_row(logic [1:0] k, logic [7:0] d, bit typed,
                           psgtne_pkg::out_item_t want);
        row_t r;
        r.it.kind = k;
        r.it.write_data = d;
        r.typed = typed;
        r.want = want;
        script.push_back(r);
    endtask

    task automatic write_cfg(psgtne_pkg::cfg_idx_t idx, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        case (idx)
            psgtne_pkg::CFG_STEP_INC: cfg_step = v;
            psgtne_pkg::CFG_VOL_MODE: cfg_ay = v[0];
            psgtne_pkg::CFG_MUTE:     cfg_mute = v[2:0];
            default:                  cfg_stereo = v[5:0];
        endcase
    endtask

    // Random traffic: mostly latch/write pairs and ticks, some reads and noise
    task automatic send_random();
        int         r;
        logic [4:0] idx;
        logic [2:0] hi;
        logic [7:0] v;
        bit         hold;
        hold = ($urandom_range(0, 199) == 0);
        r = $urandom_range(0, 99);
        idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                          : 5'($urandom_range(0, 15));
        hi = 3'($urandom_range(0, 7));
        if (r < 48) begin
            push_item(psgtne_pkg::KIND_TICK, 8'($urandom_range(0, 255)), 1'b0, '0, hold);
        end else if (r < 78) begin
            // Keep periods short most of the time so dividers fire often
            case (idx)
                5'd1, 5'd3, 5'd5, 5'd12:
                    v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                5'd0, 5'd2, 5'd4, 5'd6, 5'd11:
                    v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 15));
                default:
                    v = 8'($urandom_range(0, 255));
            endcase
            push_item(psgtne_pkg::KIND_LATCH, {hi, idx}, 1'b0, '0, hold);
            push_item(psgtne_pkg::KIND_WRITE, v, 1'b0, '0, 1'b0);
        end else if (r < 90) begin
            if ($urandom_range(0, 1)) begin
                push_item(psgtne_pkg::KIND_LATCH, {hi, idx}, 1'b0, '0, hold);
            end
            push_item(psgtne_pkg::KIND_READ, 8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
        end else begin
            push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0, hold);
        end
    endtask

    // Drain, reconfigure, then run one stretch of random traffic
    task automatic run_phase(int s_pct, int r_pct, logic [31:0] step, logic ay,
                             logic [2:0] mute, logic [5:0] stereo, int n_items);
        int stop_at;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (responses_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        write_cfg(psgtne_pkg::CFG_STEP_INC, step);
        write_cfg(psgtne_pkg::CFG_VOL_MODE, {31'd0, ay});
        write_cfg(psgtne_pkg::CFG_MUTE, {29'd0, mute});
        write_cfg(psgtne_pkg::CFG_STEREO, {26'd0, stereo});
        cfg_wr_en <= 1'b0;
        s_gap_pct = s_pct;
        r_gap_pct = r_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            send_random();
        end
    endtask

    initial begin
        psgtne_pkg::out_item_t quiet;
        quiet = '0;
        quiet.is_sample = 1'b1;

        // Shadow state and configuration at reset
        cfg_step = psgtne_pkg::STEP_INC_RESET;
        cfg_ay = 1'b0;
        cfg_mute = '0;
        cfg_stereo = psgtne_pkg::STEREO_RESET;
        for (int i = 0; i < 16; i++) begin
            regs_m[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            tone_cnt[i] = '0;
            tone_edge[i] = 1'b0;
        end
        latch_m = '0;
        phase_m = '0;
        lfsr = 17'h0ffff;
        noise_half = 1'b0;
        noise_cnt = '0;
        env_cnt = '0;
        env_pos = '0;
        env_up = 1'b0;
        env_frozen = 1'b1;

        // Directed items: reset contents, out-of-range latch, masking, envelope shape
        add_row(psgtne_pkg::KIND_READ,  8'h00, 1'b1, read_of(8'h00));
        add_row(psgtne_pkg::KIND_TICK,  8'h00, 1'b1, quiet);
        add_row(psgtne_pkg::KIND_LATCH, 8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_READ,  8'h00, 1'b1, read_of(8'h00));
        add_row(psgtne_pkg::KIND_LATCH, 8'h07, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_READ,  8'hff, 1'b1, read_of(8'h3f));
        add_row(psgtne_pkg::KIND_LATCH, 8'h0d, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_READ,  8'h00, 1'b1, read_of(8'h0f));
        add_row(psgtne_pkg::KIND_LATCH, 8'h08, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'h1f, 1'b0, '0);
        add_row(psgtne_pkg::KIND_LATCH, 8'h09, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'h0f, 1'b0, '0);
        add_row(psgtne_pkg::KIND_LATCH, 8'h0a, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_TICK,  8'hff, 1'b0, '0);
        add_row(psgtne_pkg::KIND_LATCH, 8'h00, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'h00, 1'b0, '0);
        add_row(psgtne_pkg::KIND_LATCH, 8'h2b, 1'b0, '0);
        add_row(psgtne_pkg::KIND_WRITE, 8'h01, 1'b0, '0);
        add_row(psgtne_pkg::KIND_TICK,  8'h00, 1'b0, '0);
        add_row(psgtne_pkg::KIND_TICK,  8'h55, 1'b0, '0);
        add_row(psgtne_pkg::KIND_READ,  8'haa, 1'b1, read_of(8'h01));

        // Hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        s_gap_pct = 7;
        r_gap_pct = 74;
        foreach (script[k]) begin
            push_item(script[k].it.kind, script[k].it.write_data, script[k].typed,
                      script[k].want, 1'b0);
        end

        run_phase(7, 74, 32'h0040_0000, 1'b0, 3'b000, 6'h3f, 320);
        run_phase(7, 74, 32'hffff_ffff, 1'b1, 3'b000, 6'h00, 320);
        run_phase(74, 7, $urandom, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  6'($urandom_range(0, 63)), 320);
        run_phase(74, 7, 32'h0000_0000, 1'b0, 3'b110, 6'h2a, 320);
        run_phase(0, 0, 32'h0300_0000, 1'b1, 3'b111, 6'h15, 320);
        run_phase(0, 0, $urandom_range(0, 32'h0200_0000), 1'b0, 3'b010, 6'h3f, 320);

        // Wait out the last results and the pipeline tail
        s_valid <= 1'b0;
        @(posedge aclk);
        while (responses_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (responses_due.size() != 0) begin
            report_mismatch("results still due", responses_due.size(), 0);
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/psgtne_pkg.sv
rtl/psgtne_phase.sv
rtl/psgtne_core.sv
rtl/psgtne_mix.sv
rtl/psg_tone_noise_envelope_generator.sv
rtl/psgtne_checker.sv
bench/psg_tone_noise_envelope_generator_test.sv
